// ----- design/serial_command_line_matcher_macros.svh -----
// Assertion macros shared by the command line matcher modules.
`ifndef SERIAL_COMMAND_LINE_MATCHER_MACROS_SVH
`define SERIAL_COMMAND_LINE_MATCHER_MACROS_SVH

`ifndef SYNTH
`define SCLM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define SCLM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SCLM_ASSERT(label, prop, msg)
`define SCLM_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ----- design/scl_pkg.sv -----
// Types, constants and text tables for the command line matcher.
`timescale 1ns / 1ps
package scl_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_HOLD = 1'b0,
    REG_TIMEOUT  = 1'b1
  } scl_reg_t;

  typedef enum logic [1:0] {
    EV_PONG = 2'd0,
    EV_INFO = 2'd1,
    EV_HOLD = 2'd2,
    EV_DROP = 2'd3
  } scl_event_t;

  typedef enum logic [3:0] {
    NP_SKIP   = 4'b0001,
    NP_SIGN   = 4'b0010,
    NP_DIGITS = 4'b0100,
    NP_DONE   = 4'b1000
  } scl_num_phase_t;

  typedef struct packed {
    logic        ping;
    logic        info;
    logic        hold;
    logic [15:0] hold_value;
  } scl_line_evt_t;

  localparam logic [7:0]  CMD_PING_LEN = 8'd8;
  localparam logic [7:0]  CMD_INFO_LEN = 8'd12;
  localparam logic [7:0]  CMD_HOLD_LEN = 8'd17;
  localparam logic [16:0] NUM_SAT      = 17'd65536;
  localparam logic [16:0] ELAPSED_MAX  = 17'h1FFFF;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Shared three-letter lead-in and underscore of every command.
  function automatic logic [7:0] lead_char(input logic [4:0] idx);
    logic [7:0] ch;
    case (idx)
      5'd0:    ch = 8'h48;
      5'd1:    ch = 8'h43;
      5'd2:    ch = 8'h44;
      5'd3:    ch = 8'h5F;
      default: ch = CHAR_NUL;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] ping_char(input logic [4:0] idx);
    logic [7:0] ch;
    case (idx)
      5'd4:    ch = 8'h50; // P
      5'd5:    ch = 8'h49; // I
      5'd6:    ch = 8'h4E; // N
      5'd7:    ch = 8'h47; // G
      default: ch = lead_char(idx);
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] info_char(input logic [4:0] idx);
    logic [7:0] ch;
    case (idx)
      5'd4:    ch = 8'h47; // G
      5'd5:    ch = 8'h45; // E
      5'd6:    ch = 8'h54; // T
      5'd7:    ch = 8'h5F; // _
      5'd8:    ch = 8'h49; // I
      5'd9:    ch = 8'h4E; // N
      5'd10:   ch = 8'h46; // F
      5'd11:   ch = 8'h4F; // O
      default: ch = lead_char(idx);
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] hold_char(input logic [4:0] idx);
    logic [7:0] ch;
    case (idx)
      5'd4:    ch = 8'h53; // S
      5'd5:    ch = 8'h45; // E
      5'd6:    ch = 8'h54; // T
      5'd7:    ch = 8'h5F; // _
      5'd8:    ch = 8'h4C; // L
      5'd9:    ch = 8'h45; // E
      5'd10:   ch = 8'h44; // D
      5'd11:   ch = 8'h5F; // _
      5'd12:   ch = 8'h48; // H
      5'd13:   ch = 8'h4F; // O
      5'd14:   ch = 8'h4C; // L
      5'd15:   ch = 8'h44; // D
      5'd16:   ch = 8'h7C; // |
      default: ch = lead_char(idx);
    endcase
    return ch;
  endfunction

  // Drop candidates whose text length does not fit the length seen.
  function automatic logic [2:0] check_len(input logic [2:0] flags, input logic [7:0] len);
    logic [2:0] f;
    f = flags;
    if (len != CMD_PING_LEN) f[0] = 1'b0;
    if (len != CMD_INFO_LEN) f[1] = 1'b0;
    if (len < CMD_HOLD_LEN)  f[2] = 1'b0;
    return f;
  endfunction

endpackage

// ----- design/serial_command_line_matcher.sv -----
// Top level of the serial command line matcher.
// A result passes through the input register and then the result register before it appears on the master side.
// Throughput: one input transaction per cycle; the result register keeps taking items
// while the master side is ready or the register is empty.
// Reset: synchronous active-high rst empties both registers, clears the line,
// drops the link and loads max_hold_ms = 1000 and heartbeat_timeout = 3000.
`timescale 1ns / 1ps
`include "serial_command_line_matcher_macros.svh"
module serial_command_line_matcher #(
  parameter int LINE_LENGTH = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [7:0] data_byte
  input  logic                            s_tuser,   // [0] kind
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [23:0]                     m_tdata,   // [15:0] hold_value, [16] link_up
  output logic [1:0]                      m_tuser,   // [1:0] event_code
  input  logic                            cfg_we,
  input  logic [scl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [scl_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import scl_pkg::*;

  logic        in_valid;
  logic        in_kind;
  logic [7:0]  in_byte;
  logic        advance;
  logic        step;
  logic [15:0] max_hold_ms;
  logic [15:0] heartbeat_timeout;

  scl_line_evt_t evt;
  logic          drop;
  logic          link_up;
  logic          has_result;
  scl_event_t    code;
  logic [15:0]   hold_value;

  logic        out_valid;
  scl_event_t  out_code;
  logic [15:0] out_hold;
  logic        out_link;

  assign advance  = !out_valid || m_tready;
  assign step     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  scl_line #(
    .LINE_LENGTH(LINE_LENGTH)
  ) u_line (
    .clk        (clk),
    .rst        (rst),
    .step       (step && !in_kind),
    .data_byte  (in_byte),
    .max_hold_ms(max_hold_ms),
    .evt        (evt)
  );

  scl_link u_link (
    .clk              (clk),
    .rst              (rst),
    .tick             (step && in_kind),
    .ping             (evt.ping),
    .heartbeat_timeout(heartbeat_timeout),
    .drop             (drop),
    .link_up          (link_up)
  );

  always_comb begin
    has_result = drop || evt.ping || evt.info || evt.hold;
    hold_value = '0;
    if (drop) begin
      code = EV_DROP;
    end else if (evt.ping) begin
      code = EV_PONG;
    end else if (evt.info) begin
      code = EV_INFO;
    end else begin
      code       = EV_HOLD;
      hold_value = evt.hold_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_hold_ms       <= 16'd1000;
      heartbeat_timeout <= 16'd3000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_HOLD: max_hold_ms       <= cfg_data;
        REG_TIMEOUT:  heartbeat_timeout <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_kind <= s_tuser;
      in_byte <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step && has_result;
    end
    if (advance) begin
      out_code <= code;
      out_hold <= hold_value;
      out_link <= link_up;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_code;
  assign m_tdata  = {7'd0, out_link, out_hold};

  `SCLM_ASSERT(a_drop_link_down, (m_tvalid && (m_tuser == EV_DROP)) |-> !m_tdata[16], "drop with link up")
  `SCLM_ASSERT(a_pong_link_up, (m_tvalid && (m_tuser == EV_PONG)) |-> m_tdata[16], "pong with link down")
  `SCLM_ASSERT(a_hold_only, (m_tvalid && (m_tuser != EV_HOLD)) |-> (m_tdata[15:0] == '0), "stray hold value")
  `SCLM_ASSERT_ALWAYS(a_reset_empty, rst |=> (!m_tvalid && s_tready), "registers not empty after reset")

endmodule

// ----- design/scl_line.sv -----
// Line assembly, incremental command matching and hold number parsing.
`timescale 1ns / 1ps
module scl_line #(
  parameter int LINE_LENGTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [7:0]            data_byte,
  input  logic [15:0]           max_hold_ms,
  output scl_pkg::scl_line_evt_t evt
);
  import scl_pkg::*;

  localparam int PW = $clog2(LINE_LENGTH);
  localparam logic [PW-1:0] LAST_POS = PW'(LINE_LENGTH - 1);

  logic [PW-1:0]  pos, pos_next;
  logic [2:0]     flags, flags_next;
  logic           ended, ended_next;
  scl_num_phase_t phase, phase_next;
  logic           neg, neg_next;
  logic [16:0]    value, value_next;

  logic [7:0]  pos8;
  logic        is_digit;
  logic [16:0] digit;
  logic [20:0] acc;
  logic [16:0] req;
  logic [2:0]  fl_end;

  always_comb begin
    pos8     = 8'(pos);
    is_digit = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
    digit    = 17'(data_byte - CHAR_ZERO);
    acc      = {value, 3'b000} + {2'b00, value, 1'b0} + 21'(digit);
    req      = (neg && (value != '0)) ? NUM_SAT : value;
    fl_end   = ended ? flags : check_len(flags, pos8);

    pos_next    = pos;
    flags_next  = flags;
    ended_next  = ended;
    phase_next  = phase;
    neg_next    = neg;
    value_next  = value;
    evt         = '0;
    evt.hold_value = (req > {1'b0, max_hold_ms}) ? max_hold_ms : req[15:0];

    if (step) begin
      if (data_byte == CHAR_CR) begin
      end else if (data_byte == CHAR_LF) begin
        if (pos != '0) begin
          evt.ping = fl_end[0];
          evt.info = !fl_end[0] && fl_end[1];
          evt.hold = !fl_end[0] && !fl_end[1] && fl_end[2];
        end
        pos_next   = '0;
        flags_next = 3'b111;
        ended_next = 1'b0;
        phase_next = NP_SKIP;
        neg_next   = 1'b0;
        value_next = '0;
      end else if (pos < LAST_POS) begin
        pos_next = pos + 1'b1;
        if (!ended) begin
          if (data_byte == CHAR_NUL) begin
            ended_next = 1'b1;
            flags_next = check_len(flags, pos8);
          end else begin
            if ((pos8 >= CMD_PING_LEN) || (data_byte != ping_char(pos8[4:0])))
              flags_next[0] = 1'b0;
            if ((pos8 >= CMD_INFO_LEN) || (data_byte != info_char(pos8[4:0])))
              flags_next[1] = 1'b0;
            if (pos8 < CMD_HOLD_LEN) begin
              if (data_byte != hold_char(pos8[4:0])) flags_next[2] = 1'b0;
            end else if (flags[2]) begin
              case (phase)
                NP_SKIP: begin
                  if (data_byte inside {CHAR_SPACE, [8'h09:8'h0D]}) begin
                  end else if (data_byte inside {CHAR_PLUS, CHAR_MINUS}) begin
                    neg_next   = (data_byte == CHAR_MINUS);
                    phase_next = NP_SIGN;
                  end else if (is_digit) begin
                    value_next = digit;
                    phase_next = NP_DIGITS;
                  end else begin
                    phase_next = NP_DONE;
                  end
                end
                NP_SIGN: begin
                  if (is_digit) begin
                    value_next = digit;
                    phase_next = NP_DIGITS;
                  end else begin
                    neg_next   = 1'b0;
                    value_next = '0;
                    phase_next = NP_DONE;
                  end
                end
                NP_DIGITS: begin
                  if (is_digit) begin
                    value_next = (acc > 21'(NUM_SAT)) ? NUM_SAT : acc[16:0];
                  end else begin
                    phase_next = NP_DONE;
                  end
                end
                default: begin
                end
              endcase
            end
          end
        end
      end else begin
        pos_next   = '0;
        flags_next = 3'b111;
        ended_next = 1'b0;
        phase_next = NP_SKIP;
        neg_next   = 1'b0;
        value_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      flags <= 3'b111;
      ended <= 1'b0;
      phase <= NP_SKIP;
      neg   <= 1'b0;
      value <= '0;
    end else begin
      pos   <= pos_next;
      flags <= flags_next;
      ended <= ended_next;
      phase <= phase_next;
      neg   <= neg_next;
      value <= value_next;
    end
  end

endmodule

// ----- design/scl_link.sv -----
// Heartbeat supervision: elapsed tick counter and link state.
`timescale 1ns / 1ps
`include "serial_command_line_matcher_macros.svh"
module scl_link (
  input  logic        clk,
  input  logic        rst,
  input  logic        tick,
  input  logic        ping,
  input  logic [15:0] heartbeat_timeout,
  output logic        drop,
  output logic        link_up
);
  import scl_pkg::*;

  logic [16:0] elapsed, elapsed_next;
  logic        connected, connected_next;

  always_comb begin
    elapsed_next   = elapsed;
    connected_next = connected;
    drop           = 1'b0;
    if (tick) begin
      if (elapsed != ELAPSED_MAX) elapsed_next = elapsed + 1'b1;
      if (connected && (elapsed_next > {1'b0, heartbeat_timeout})) begin
        connected_next = 1'b0;
        drop           = 1'b1;
      end
    end else if (ping) begin
      elapsed_next   = '0;
      connected_next = 1'b1;
    end
    link_up = connected_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed   <= '0;
      connected <= 1'b0;
    end else begin
      elapsed   <= elapsed_next;
      connected <= connected_next;
    end
  end

  `SCLM_ASSERT(a_link_rise_clears, $rose(connected) |-> (elapsed == '0), "link up with stale count")

endmodule
